[design/shabs_pkg.sv]
// ----------------------------------------------------------------------------
// shabs_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package shabs_pkg;

  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned BLOCK_BYTES   = 64;
  localparam int unsigned LENGTH_OFFSET = 56;
  localparam int unsigned ROUNDS        = 64;
  localparam logic [7:0]  PAD_BYTE      = 8'h80;

  localparam logic [5:0] LAST_BYTE_POS = 6'(BLOCK_BYTES - 1);
  localparam logic [5:0] LENGTH_POS    = 6'(LENGTH_OFFSET);
  localparam logic [5:0] LAST_ROUND    = 6'(ROUNDS - 1);
  localparam logic [2:0] LAST_WORD_POS = 3'd7;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } eng_state_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

[design/shabs_front.sv]
// ----------------------------------------------------------------------------
// shabs_front
// Accepts input items, tags them as append or finish commands and holds
// them in a small queue for the hash engine.
// ----------------------------------------------------------------------------
module shabs_front #(
  parameter int unsigned Depth = shabs_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [7:0]          data_byte,
  output logic                q_valid,
  output shabs_pkg::cmd_t     q_cmd,
  input  logic                q_pop
);
  import shabs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            queue_mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            push;
  cmd_t            cmd_in;

  assign in_stall = (count == FullCnt);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_cmd    = queue_mem[rd_ptr];

  always_comb begin
    cmd_in.op   = action ? OP_FINISH : OP_APPEND;
    cmd_in.data = data_byte;
  end

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + CntW'(1);
    end else if (!push && q_pop) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= cmd_in;
    end
  end

endmodule

[design/shabs_engine.sv]
// ----------------------------------------------------------------------------
// shabs_engine
// Packs bytes into the 16-word block window, pads on finish, runs one
// SHA-256 round per cycle and shifts the digest out through a register.
// ----------------------------------------------------------------------------
module shabs_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  shabs_pkg::cmd_t     q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index,
  output logic                last_word
);
  import shabs_pkg::*;

  eng_state_t  state;
  eng_state_t  state_next;

  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic        finishing;
  logic        last_block;
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];

  // decoded controls
  logic        take;
  logic        byte_we;
  logic [7:0]  byte_val;
  logic        len_we;
  logic        start_block;
  logic        final_block;
  logic        load_out;

  // round datapath
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] sched_new;

  assign take     = (state == ST_IDLE) && q_valid;
  assign q_pop    = take;
  assign load_out = (state == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (fill == LAST_BYTE_POS) begin
            state_next = ST_ROUND;
          end else if (q_cmd.op == OP_FINISH) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill == LENGTH_POS || fill == LAST_BYTE_POS) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == LAST_ROUND) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (last_block) begin
          state_next = ST_OUT;
        end else if (finishing) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (load_out && out_idx == LAST_WORD_POS) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    byte_we     = 1'b0;
    byte_val    = 8'h00;
    len_we      = 1'b0;
    start_block = 1'b0;
    final_block = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          byte_we     = 1'b1;
          byte_val    = (q_cmd.op == OP_FINISH) ? PAD_BYTE : q_cmd.data;
          start_block = (fill == LAST_BYTE_POS);
        end
      end
      ST_PAD: begin
        if (fill == LENGTH_POS) begin
          len_we      = 1'b1;
          start_block = 1'b1;
          final_block = 1'b1;
        end else begin
          byte_we     = 1'b1;
          start_block = (fill == LAST_BYTE_POS);
        end
      end
      ST_ROUND, ST_FOLD, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ch        = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj       = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1        = v[7] + big_sigma1(v[4]) + ch + round_k(rnd) + w[0];
    t2        = big_sigma0(v[0]) + maj;
    sched_new = small_sigma1(w[14]) + w[9] + small_sigma0(w[1]) + w[0];
  end

  // control and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      message_bits <= '0;
      finishing    <= 1'b0;
      last_block   <= 1'b0;
      rnd          <= '0;
      out_idx      <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= iv_word(3'(i));
      end
    end else begin
      state <= state_next;
      if (byte_we) begin
        fill <= fill + 6'd1;
      end
      if (take) begin
        if (q_cmd.op == OP_APPEND) begin
          message_bits <= message_bits + 64'd8;
        end else begin
          finishing <= 1'b1;
        end
      end
      if (start_block) begin
        last_block <= final_block;
        rnd        <= '0;
      end else if (state == ST_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (state == ST_FOLD) begin
        for (int i = 0; i < 8; i++) begin
          h[i] <= h[i] + v[i];
        end
      end
      out_valid <= load_out || (out_valid && out_stall);
      if (load_out) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == LAST_WORD_POS) begin
          // restart for the next message
          for (int i = 0; i < 8; i++) begin
            h[i] <= iv_word(3'(i));
          end
          fill         <= '0;
          message_bits <= '0;
          finishing    <= 1'b0;
          last_block   <= 1'b0;
        end
      end
    end
  end

  // block window, working variables and digest register
  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= sched_new;
      v[7]  <= v[6];
      v[6]  <= v[5];
      v[5]  <= v[4];
      v[4]  <= v[3] + t1;
      v[3]  <= v[2];
      v[2]  <= v[1];
      v[1]  <= v[0];
      v[0]  <= t1 + t2;
    end else begin
      if (byte_we) begin
        w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= byte_val;
      end
      if (len_we) begin
        w[14] <= message_bits[63:32];
        w[15] <= message_bits[31:0];
      end
      if (start_block) begin
        for (int i = 0; i < 8; i++) begin
          v[i] <= h[i];
        end
      end
    end
    if (load_out) begin
      digest_word <= h[out_idx];
      word_index  <= out_idx;
      last_word   <= (out_idx == LAST_WORD_POS);
    end
  end

endmodule

[design/sha256_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one byte or finish command per input item.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): action 0 appends data_byte to the
// message, action 1 finishes it. Items go into a short command queue, so
// the sender can keep going while the engine compresses a block.
// Output channel (out_valid / out_stall): on finish, eight items carry the
// digest, word 0 first, word_index 0..7, last_word set on word 7.
// Timing: an accepted item is written into the queue memory and count
// registers before the engine sees it. An appended byte is taken in
// ST_IDLE; the 64th byte of a block then starts the rounds (ST_ROUND) and
// the fold (ST_FOLD), run by the single shared round unit. A finish
// writes the 0x80 byte, then zero pad bytes (up to 63), then loads the
// length; each padding block (one or two blocks) runs the rounds and the
// fold, then the eight digest words are loaded into the output register.
// After the last one is loaded the block restarts with the initial hash
// for a new message. If the receiver stalls, the current word holds and
// the engine waits; the queue then fills and in_stall rises.
// Reset (rst, synchronous) empties the queue and restarts the message.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher #(
  parameter int unsigned QueueDepth = shabs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import shabs_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  shabs_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .data_byte(data_byte),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  shabs_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

endmodule
